// ----- hw/rtl/gsa_pkg.sv -----
// Shared types and constants for the generational slot allocator.
// Request and response beat layouts, action codes and parameter defaults.
// No dependencies.
package gsa_pkg;

	// parameter defaults for the top level
	localparam int unsigned SLOT_COUNT_DEF = 256;
	localparam int unsigned GEN_BITS_DEF   = 8;

	// request action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// one request beat
	typedef struct packed {
		logic       action;
		logic [7:0] req_generation;
		logic [7:0] req_index;
	} req_beat_t;

	// one response beat
	typedef struct packed {
		logic       ok;
		logic [7:0] out_generation;
		logic [7:0] out_index;
	} rsp_beat_t;

endpackage

// ----- hw/rtl/generational_slot_allocator.sv -----
// Response: a response beat is registered from S_UPDATE after its request beat has passed
// through S_SLOT_RD; S_UPDATE waits while an earlier response beat is still held by rsp_stall.
// Requests: a new request is taken only in S_IDLE, once the stack-top read, the slot
// table read that depends on it, and the slot write-back that follows are done.
// Reset: control counters clear at once and there is no clearing pass; slots at or
// above the count of slots ever handed out read as generation 0, free.
// Depends on gsa_pkg.
module generational_slot_allocator
	import gsa_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int unsigned GEN_BITS   = GEN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [31:0] GEN_MASK32 = 32'((64'd1 << GEN_BITS) - 64'd1);

	typedef struct packed {
		logic [GEN_BITS-1:0] gen;
		logic                occ;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_SLOT_RD = 3'b010,
		S_UPDATE  = 3'b100
	} state_t;

	// memories
	slot_t            slot_mem  [SLOT_COUNT];
	logic [IDX_W-1:0] stack_mem [SLOT_COUNT];

	state_t           state_q;
	logic [CNT_W-1:0] free_count_q;
	logic [CNT_W-1:0] used_slots_q;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	req_beat_t        req_q;
	logic [IDX_W-1:0] stack_rd_q;
	slot_t            slot_rd_q;
	logic [IDX_W-1:0] idx_q;
	logic             fresh_q;
	logic             fail_q;

	logic             req_acc;
	logic             upd_go;
	logic [CNT_W-1:0] top_cnt;
	logic [IDX_W-1:0] top_addr;
	logic [31:0]      req_idx_ext;
	logic [31:0]      used_ext;
	logic             stack_nonempty;
	logic             room_left;
	logic [IDX_W-1:0] idx_d;
	logic             fresh_d;
	logic             fail_d;
	logic [GEN_BITS-1:0] base_gen;
	logic [GEN_BITS-1:0] new_gen;
	logic [31:0]      new_gen_ext;
	logic [31:0]      idx_ext;
	logic             gen_match;
	logic             alloc_ok;
	logic             free_ok;
	rsp_beat_t        rsp_d;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign upd_go    = !(rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stack top and slot selection
	assign top_cnt        = free_count_q - CNT_W'(1);
	assign top_addr       = top_cnt[IDX_W-1:0];
	assign req_idx_ext    = 32'(req_q.req_index);
	assign used_ext       = 32'(used_slots_q);
	assign stack_nonempty = (free_count_q != '0);
	assign room_left      = (used_slots_q < CNT_W'(SLOT_COUNT));

	always_comb begin
		if (req_q.action == ACT_ALLOC) begin
			fresh_d = !stack_nonempty && room_left;
			fail_d  = !stack_nonempty && !room_left;
			idx_d   = stack_nonempty ? stack_rd_q : used_slots_q[IDX_W-1:0];
		end else begin
			fresh_d = 1'b0;
			// below the used count also keeps it inside the table
			fail_d  = (req_idx_ext >= used_ext);
			idx_d   = req_idx_ext[IDX_W-1:0];
		end
	end

	// update: new generation and the response
	assign base_gen    = fresh_q ? '0 : slot_rd_q.gen;
	assign new_gen     = base_gen + GEN_BITS'(1);
	assign new_gen_ext = 32'(new_gen);
	assign idx_ext     = 32'(idx_q);
	assign gen_match   = (32'(slot_rd_q.gen) == (32'(req_q.req_generation) & GEN_MASK32));
	assign alloc_ok    = (req_q.action == ACT_ALLOC) && !fail_q;
	assign free_ok     = (req_q.action == ACT_FREE) && !fail_q && slot_rd_q.occ && gen_match;

	always_comb begin
		rsp_d = '0;
		if (alloc_ok) begin
			rsp_d.ok             = 1'b1;
			rsp_d.out_generation = new_gen_ext[7:0];
			rsp_d.out_index      = idx_ext[7:0];
		end else if (free_ok) begin
			rsp_d.ok = 1'b1;
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_count_q <= '0;
			used_slots_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_UPDATE && upd_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_SLOT_RD;
					end
				end
				S_SLOT_RD: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (upd_go) begin
						state_q <= S_IDLE;
						if (alloc_ok) begin
							if (fresh_q) begin
								used_slots_q <= used_slots_q + CNT_W'(1);
							end else begin
								free_count_q <= top_cnt;
							end
						end else if (free_ok && free_count_q < CNT_W'(SLOT_COUNT)) begin
							free_count_q <= free_count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if (state_q == S_SLOT_RD) begin
			idx_q   <= idx_d;
			fresh_q <= fresh_d;
			fail_q  <= fail_d;
		end
		if (state_q == S_UPDATE && upd_go) begin
			rsp_q <= rsp_d;
		end
	end

	// free stack: read the top on accept, push on a good free
	always_ff @(posedge clk) begin
		if (req_acc) begin
			stack_rd_q <= stack_mem[top_addr];
		end
		if (state_q == S_UPDATE && upd_go && free_ok && free_count_q < CNT_W'(SLOT_COUNT)) begin
			stack_mem[free_count_q[IDX_W-1:0]] <= idx_q;
		end
	end

	// slot table: read the chosen slot, write back on success
	always_ff @(posedge clk) begin
		if (state_q == S_SLOT_RD) begin
			slot_rd_q <= slot_mem[idx_d];
		end
		if (state_q == S_UPDATE && upd_go) begin
			if (alloc_ok) begin
				slot_mem[idx_q] <= '{gen: new_gen, occ: 1'b1};
			end else if (free_ok) begin
				slot_mem[idx_q] <= '{gen: slot_rd_q.gen, occ: 1'b0};
			end
		end
	end

	// checks
	a_free_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= used_slots_q)
		else $error("free stack deeper than slots handed out");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_slots_q <= CNT_W'(SLOT_COUNT))
		else $error("used slot count beyond table");

	a_alloc_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && upd_go && alloc_ok) |=>
		(free_count_q == $past(free_count_q) - CNT_W'(1)
		|| used_slots_q == $past(used_slots_q) + CNT_W'(1)))
		else $error("allocate took no slot");

	a_bad_free_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && upd_go && req_q.action == ACT_FREE && !free_ok) |=>
		($stable(free_count_q) && $stable(used_slots_q)))
		else $error("rejected free changed counters");

	a_rsp_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_UPDATE))
		else $error("response raised outside update");

endmodule
